// ===== sv/mspfc_pkg.sv =====
// mspfc_pkg: types and constants shared by the frame checker modules
// no dependencies
`timescale 1ns / 1ps

package mspfc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
  localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;

  localparam logic [BYTE_W-1:0] CNT_MAX       = 8'hFF;
  localparam logic [BYTE_W-1:0] THRESH_RESET  = 8'd3;

  localparam logic [APB_AW-1:0] ADDR_BAD_THRESH = 3'd0;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_HDR_M    = 7'b0000010,
    PH_HDR_DIR  = 7'b0000100,
    PH_LEN      = 7'b0001000,
    PH_CMD      = 7'b0010000,
    PH_PAYLOAD  = 7'b0100000,
    PH_CHECKSUM = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic              frame_done;
    logic              frame_good;
    logic [BYTE_W-1:0] frame_command;
    logic              device_detected;
    logic [BYTE_W-1:0] good_frames;
    logic [BYTE_W-1:0] bad_frames;
  } result_t;

endpackage

// ===== sv/mspfc_parser.sv =====
// mspfc_parser: frame parser state, checksum and saturating frame counters
// depends on mspfc_pkg
`timescale 1ns / 1ps

module mspfc_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic [mspfc_pkg::BYTE_W-1:0]   rx_byte_i,
  input  logic [mspfc_pkg::BYTE_W-1:0]   threshold_i,
  output mspfc_pkg::result_t             result_o
);
  import mspfc_pkg::*;

  phase_e            phase_q, phase_d;
  logic [BYTE_W-1:0] len_q, len_d;
  logic [BYTE_W-1:0] cmd_q, cmd_d;
  logic [BYTE_W-1:0] xor_q, xor_d;
  logic [BYTE_W-1:0] cnt_q, cnt_d;
  logic [BYTE_W-1:0] good_q, good_d;
  logic [BYTE_W-1:0] bad_q, bad_d;
  logic              det_q, det_d;
  logic [BYTE_W-1:0] cnt_inc;
  logic              done;
  logic              good;
  logic              clear;

  assign cnt_inc = cnt_q + BYTE_W'(1);

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cmd_d   = cmd_q;
    xor_d   = xor_q;
    cnt_d   = cnt_q;
    good_d  = good_q;
    bad_d   = bad_q;
    det_d   = det_q;
    done    = 1'b0;
    good    = 1'b0;
    clear   = 1'b0;
    unique case (phase_q)
      PH_HDR_M: begin
        if (rx_byte_i == CH_M) begin
          phase_d = PH_HDR_DIR;
        end else begin
          clear = 1'b1;
        end
      end
      PH_HDR_DIR: begin
        if (rx_byte_i == CH_LT || rx_byte_i == CH_GT) begin
          phase_d = PH_LEN;
        end else begin
          clear = 1'b1;
        end
      end
      PH_LEN: begin
        len_d   = rx_byte_i;
        xor_d   = rx_byte_i;
        phase_d = PH_CMD;
      end
      PH_CMD: begin
        cmd_d   = rx_byte_i;
        xor_d   = xor_q ^ rx_byte_i;
        cnt_d   = '0;
        phase_d = (len_q == '0) ? PH_CHECKSUM : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        xor_d = xor_q ^ rx_byte_i;
        cnt_d = cnt_inc;
        if (cnt_inc >= len_q) begin
          phase_d = PH_CHECKSUM;
        end
      end
      PH_CHECKSUM: begin
        done = 1'b1;
        if (rx_byte_i == xor_q) begin
          good = 1'b1;
          if (good_q != CNT_MAX) begin
            good_d = good_q + BYTE_W'(1);
          end
        end else if (bad_q != CNT_MAX) begin
          bad_d = bad_q + BYTE_W'(1);
        end
        if (good_d != '0 || bad_d >= threshold_i) begin
          det_d = 1'b1;
        end
        clear = 1'b1;
      end
      default: begin
        phase_d = (rx_byte_i == CH_DOLLAR) ? PH_HDR_M : PH_IDLE;
      end
    endcase
    // frame command is sampled before a finished frame clears the state
    result_o.frame_command = clear ? (done ? cmd_q : '0) : cmd_d;
    if (clear) begin
      phase_d = PH_IDLE;
      len_d   = '0;
      cmd_d   = '0;
      xor_d   = '0;
      cnt_d   = '0;
    end
    result_o.frame_done      = done;
    result_o.frame_good      = good;
    result_o.device_detected = det_d;
    result_o.good_frames     = good_d;
    result_o.bad_frames      = bad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      len_q   <= '0;
      cmd_q   <= '0;
      xor_q   <= '0;
      cnt_q   <= '0;
      good_q  <= '0;
      bad_q   <= '0;
      det_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cmd_q   <= cmd_d;
      xor_q   <= xor_d;
      cnt_q   <= cnt_d;
      good_q  <= good_d;
      bad_q   <= bad_d;
      det_q   <= det_d;
    end
  end

endmodule

// ===== sv/msp_v1_frame_checker_top.sv =====
// Frame checker for MSP v1 traffic. Each received byte is one input item and
// yields exactly one result item carrying frame status and the running good and
// bad frame counts (saturating at 255). Throughput is one byte per clock while
// the consumer takes the results; an accepted byte passes from the input
// register through the parser into the result register. A result held by the
// consumer keeps the byte behind it in the input register, and input ready drops
// only while both registers are full and the result is not taken. The bad-frame
// detection threshold is written over the APB port at address 0 and resets to 3.
// depends on mspfc_pkg and mspfc_parser
`timescale 1ns / 1ps

module msp_v1_frame_checker_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mspfc_pkg::APB_AW-1:0]  paddr,
  input  logic [mspfc_pkg::APB_DW-1:0]  pwdata,
  output logic [mspfc_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  input  logic                          rx_valid_i,
  output logic                          rx_ready_o,
  input  logic [mspfc_pkg::BYTE_W-1:0]  rx_byte_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic                          frame_done_o,
  output logic                          frame_good_o,
  output logic [mspfc_pkg::BYTE_W-1:0]  frame_command_o,
  output logic                          device_detected_o,
  output logic [mspfc_pkg::BYTE_W-1:0]  good_frames_o,
  output logic [mspfc_pkg::BYTE_W-1:0]  bad_frames_o
);
  import mspfc_pkg::*;

  logic [BYTE_W-1:0] thresh_q;
  logic              in_valid_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              res_valid_q;
  result_t           res_q;
  result_t           res_d;
  logic              res_free;
  logic              step;

  // apb register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_BAD_THRESH) ? APB_DW'(thresh_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_BAD_THRESH) begin
      thresh_q <= pwdata[BYTE_W-1:0];
    end
  end

  // pipeline control
  assign res_free   = !res_valid_q || res_ready_i;
  assign step       = in_valid_q && res_free;
  assign rx_ready_o = !in_valid_q || res_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (rx_ready_o) begin
        in_valid_q <= rx_valid_i;
      end
      if (res_free) begin
        res_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  mspfc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rx_byte_i   (in_byte_q),
    .threshold_i (thresh_q),
    .result_o    (res_d)
  );

  assign res_valid_o       = res_valid_q;
  assign frame_done_o      = res_q.frame_done;
  assign frame_good_o      = res_q.frame_good;
  assign frame_command_o   = res_q.frame_command;
  assign device_detected_o = res_q.device_detected;
  assign good_frames_o     = res_q.good_frames;
  assign bad_frames_o      = res_q.bad_frames;

endmodule
